FILE: hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared widths, constants, sector codes and item types of the converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_W = 8;
    localparam int RGB_W  = 3 * CHAN_W;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 13;

    localparam int DIV_NW = 21;
    localparam int DIV_QW = 13;

    localparam int HUE_SECTOR = 3840;
    localparam int HUE_FULL   = 23040;
    localparam int OFFS_GREEN = 7680;
    localparam int OFFS_BLUE  = 15360;
    localparam int PERCENT    = 6400;

    localparam int              BRI_MW    = 34;
    localparam logic [BRI_MW-1:0] BRI_MUL = 34'd13474412800;
    localparam int              BRI_PW    = CHAN_W + BRI_MW;
    localparam int              BRI_SHIFT = 29;

    localparam int MQ_DEPTH   = 4;
    localparam int MQ_AW      = $clog2(MQ_DEPTH);
    localparam int OBUF_DEPTH = 32;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int PIPE_LEN   = DIV_QW + 1;

    typedef enum logic [1:0] {
        SEC_GREY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic [CHAN_W-1:0]   mag;
        logic [CHAN_W-1:0]   spread;
        logic [CHAN_W-1:0]   mx;
    } cls_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [SAT_W-1:0] bri;
    } res_t;

endpackage

FILE: hdl/rhc_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter front end
// Accepts pixels, finds max, min, spread and the leading channel, and writes
// the classified item into the middle queue.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                         push,
    input  logic [rhc_pkg::RGB_W-1:0]    rgb_word,
    output logic                         full,
    input  logic                         q_full,
    output logic                         q_wr,
    output rhc_pkg::cls_t                q_data
);
    import rhc_pkg::*;

    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] op_a;
    logic [CHAN_W-1:0] op_b;

    assign r = rgb_word[3*CHAN_W-1:2*CHAN_W];
    assign g = rgb_word[2*CHAN_W-1:CHAN_W];
    assign b = rgb_word[CHAN_W-1:0];

    always_comb
    begin
        mx = r;
        mn = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end

        q_data.mx     = mx;
        q_data.spread = mx - mn;
        if (mx == mn)
        begin
            q_data.sector = SEC_GREY;
            op_a          = g;
            op_b          = b;
        end
        else if (mx == r)
        begin
            q_data.sector = SEC_RED;
            op_a          = g;
            op_b          = b;
        end
        else if (mx == g)
        begin
            q_data.sector = SEC_GREEN;
            op_a          = b;
            op_b          = r;
        end
        else
        begin
            q_data.sector = SEC_BLUE;
            op_a          = r;
            op_b          = g;
        end
        q_data.neg = (op_a < op_b);
        q_data.mag = q_data.neg ? (op_b - op_a) : (op_a - op_b);
    end

    assign full = q_full;
    assign q_wr = push & ~q_full;

endmodule

FILE: hdl/rhc_queue.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter middle queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rhc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rhc_pkg::cls_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output rhc_pkg::cls_t rd_data,
    output logic          empty
);
    import rhc_pkg::*;

    cls_t             mem_reg [MQ_DEPTH];
    logic [MQ_AW-1:0] wr_ptr_reg;
    logic [MQ_AW-1:0] wr_ptr_next;
    logic [MQ_AW-1:0] rd_ptr_reg;
    logic [MQ_AW-1:0] rd_ptr_next;
    logic [MQ_AW:0]   cnt_reg;
    logic [MQ_AW:0]   cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == (MQ_AW+1)'(MQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/rhc_div.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter divider
// Pipelined restoring divider of a 21-bit numerator by an 8-bit divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhc_div (
    input  logic                         clk,
    input  logic [rhc_pkg::DIV_NW-1:0]   num,
    input  logic [rhc_pkg::CHAN_W-1:0]   den,
    output logic [rhc_pkg::DIV_QW-1:0]   quo
);
    import rhc_pkg::*;

    logic [DIV_NW-1:0] rem_reg [DIV_QW];
    logic [CHAN_W-1:0] den_reg [DIV_QW];
    logic [DIV_QW-1:0] quo_reg [DIV_QW];

    for (genvar k = 0; k < DIV_QW; k++)
    begin : g_stage
        logic [DIV_NW-1:0] rem_in;
        logic [CHAN_W-1:0] den_in;
        logic [DIV_QW-1:0] quo_in;
        logic [DIV_NW-1:0] trial;
        logic              fits;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = DIV_NW'(den_in) << (DIV_QW - 1 - k);
        assign fits  = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= fits ? rem_in - trial : rem_in;
            den_reg[k] <= den_in;
            quo_reg[k] <= quo_in | (DIV_QW'(fits) << (DIV_QW - 1 - k));
        end
    end

    assign quo = quo_reg[DIV_QW-1];

endmodule

FILE: hdl/rhc_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter back end
// Takes classified items from the middle queue, divides for hue and
// saturation, scales the maximum for value and buffers the results.
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  rhc_pkg::cls_t               q_data,
    output logic                        q_take,
    input  logic                        pop,
    output logic                        empty,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::SAT_W-1:0]   saturation,
    output logic [rhc_pkg::SAT_W-1:0]   brightness
);
    import rhc_pkg::*;

    typedef struct packed {
        sector_t          sector;
        logic             neg;
        logic             mx_zero;
        logic [SAT_W-1:0] bri;
    } side_t;

    side_t             side_reg [PIPE_LEN];
    side_t             side_next;
    logic [PIPE_LEN-1:0] vld_reg;
    logic [DIV_NW-1:0] hue_num_reg;
    logic [DIV_NW-1:0] sat_num_reg;
    logic [CHAN_W-1:0] spread_reg;
    logic [CHAN_W-1:0] mx_reg;
    logic [BRI_PW-1:0] bri_prod;
    logic [DIV_QW-1:0] hue_quo;
    logic [DIV_QW-1:0] sat_quo;
    logic [HUE_W-1:0]  hue_q;
    res_t              res_next;
    side_t             last;

    res_t               obuf_mem [OBUF_DEPTH];
    logic [OBUF_AW-1:0] wr_ptr_reg;
    logic [OBUF_AW-1:0] rd_ptr_reg;
    logic [OBUF_AW:0]   obuf_cnt_reg;
    logic [OBUF_AW:0]   obuf_cnt_next;
    logic [OBUF_AW:0]   credit_reg;
    logic [OBUF_AW:0]   credit_next;
    logic               obuf_wr;
    logic               obuf_rd;

    assign q_take  = ~q_empty & (credit_reg != (OBUF_AW+1)'(OBUF_DEPTH));
    assign bri_prod = BRI_PW'(q_data.mx) * BRI_PW'(BRI_MUL);

    always_comb
    begin
        side_next.sector  = q_data.sector;
        side_next.neg     = q_data.neg;
        side_next.mx_zero = (q_data.mx == '0);
        side_next.bri     = bri_prod[BRI_SHIFT +: SAT_W];
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        hue_num_reg <= DIV_NW'(q_data.mag) * DIV_NW'(HUE_SECTOR);
        sat_num_reg <= DIV_NW'(q_data.spread) * DIV_NW'(PERCENT);
        spread_reg  <= q_data.spread;
        mx_reg      <= q_data.mx;
        for (int k = 1; k < PIPE_LEN; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], q_take};
        end
    end

    rhc_div u_hue_div (
        .clk (clk),
        .num (hue_num_reg),
        .den (spread_reg),
        .quo (hue_quo)
    );

    rhc_div u_sat_div (
        .clk (clk),
        .num (sat_num_reg),
        .den (mx_reg),
        .quo (sat_quo)
    );

    assign last  = side_reg[PIPE_LEN-1];
    assign hue_q = HUE_W'(hue_quo);

    always_comb
    begin
        case (last.sector)
            SEC_RED:
            begin
                if (!last.neg)
                begin
                    res_next.hue = hue_q;
                end
                else if (hue_q == '0)
                begin
                    res_next.hue = '0;
                end
                else
                begin
                    res_next.hue = HUE_W'(HUE_FULL) - hue_q;
                end
            end
            SEC_GREEN:
            begin
                res_next.hue = last.neg ? HUE_W'(OFFS_GREEN) - hue_q
                                        : HUE_W'(OFFS_GREEN) + hue_q;
            end
            SEC_BLUE:
            begin
                res_next.hue = last.neg ? HUE_W'(OFFS_BLUE) - hue_q
                                        : HUE_W'(OFFS_BLUE) + hue_q;
            end
            default:
            begin
                res_next.hue = '0;
            end
        endcase
        res_next.sat = last.mx_zero ? '0 : SAT_W'(sat_quo);
        res_next.bri = last.bri;
    end

    assign obuf_wr = vld_reg[PIPE_LEN-1];
    assign empty   = (obuf_cnt_reg == '0);
    assign obuf_rd = pop & ~empty;

    always_comb
    begin
        obuf_cnt_next = obuf_cnt_reg;
        if (obuf_wr && !obuf_rd)
        begin
            obuf_cnt_next = obuf_cnt_reg + 1'b1;
        end
        else if (!obuf_wr && obuf_rd)
        begin
            obuf_cnt_next = obuf_cnt_reg - 1'b1;
        end
        credit_next = credit_reg;
        if (q_take && !obuf_rd)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!q_take && obuf_rd)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            obuf_cnt_reg <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg   <= obuf_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
            rd_ptr_reg   <= obuf_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
            obuf_cnt_reg <= obuf_cnt_next;
            credit_reg   <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (obuf_wr)
        begin
            obuf_mem[wr_ptr_reg] <= res_next;
        end
    end

    assign hue        = obuf_mem[rd_ptr_reg].hue;
    assign saturation = obuf_mem[rd_ptr_reg].sat;
    assign brightness = obuf_mem[rd_ptr_reg].bri;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (OBUF_AW+1)'(OBUF_DEPTH))
        else $error("Result credit exceeds the buffer depth.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_wr |-> (obuf_cnt_reg < (OBUF_AW+1)'(OBUF_DEPTH)))
        else $error("Result buffer written while full.");

    a_cnt_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_cnt_reg <= credit_reg)
        else $error("Buffered items exceed the issued items.");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (hue < HUE_W'(HUE_FULL)))
        else $error("Hue of the waiting item is out of range.");

endmodule

FILE: hdl/rgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter top level
// Converts packed 24-bit RGB pixels to hue, saturation and value in fixed
// point with 6 fraction bits.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock cycle while full is low and gives one
// result item per pixel in order. A pixel pushed into the middle queue reaches
// the result ports through the operand stage that takes it from the queue, the
// 13 stages of the two restoring dividers that form hue and saturation, and the
// write into the 32-entry result buffer.
// Items are sent into the dividers only while the result buffer has room
// reserved for them, so holding pop low fills that buffer and then the
// 4-entry middle queue before full rises.
module rgb_to_hsv_converter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [rhc_pkg::RGB_W-1:0]   rgb_word,
    input  logic                        pop,
    output logic                        empty,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::SAT_W-1:0]   saturation,
    output logic [rhc_pkg::SAT_W-1:0]   brightness
);
    import rhc_pkg::*;

    cls_t wr_data;
    cls_t rd_data;
    logic q_wr;
    logic q_full;
    logic q_empty;
    logic q_take;

    rhc_front u_front (
        .push     (push),
        .rgb_word (rgb_word),
        .full     (full),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (wr_data)
    );

    rhc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (wr_data),
        .full    (q_full),
        .rd_en   (q_take),
        .rd_data (rd_data),
        .empty   (q_empty)
    );

    rhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (rd_data),
        .q_take     (q_take),
        .pop        (pop),
        .empty      (empty),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule
